// ===== design/hcm_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hcm_pkg: shared types and constants for the HOP corrected mass block
// Field widths, fixed-point limits, command codes, and the command and
// status records that join the controller and the datapath.
// ---------------------------------------------------------------------------
package hcm_pkg;

    // Field widths
    localparam int COMP_W   = 31;
    localparam int CMD_W    = 3;
    localparam int CFG_W    = 20;
    localparam int FACTOR_W = 24;
    localparam int MASS_W   = 34;

    // Arithmetic unit widths
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int DIV_N_W  = 64;
    localparam int DIV_D_W  = 32;
    localparam int SQ_IN_W  = 66;
    localparam int SQ_OUT_W = SQ_IN_W / 2;

    // Default fraction bits of the scale factor
    localparam int HCM_FRAC_BITS = 16;

    // Constants
    localparam logic [CFG_W-1:0]    LEPTON_MASS_RESET = 20'd511;
    localparam logic [FACTOR_W-1:0] FACTOR_MAX        = 24'hFF_FFFF;
    localparam logic [COMP_W-1:0]   COMP_NEG_MAG      = 31'h4000_0000;
    localparam logic [COMP_W-1:0]   COMP_POS_MAX      = 31'h3FFF_FFFF;

    // Input item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_END_VTX = 3'd0,
        CMD_PRI_VTX = 3'd1,
        CMD_HADRON  = 3'd2,
        CMD_DILEP   = 3'd3,
        CMD_LEP1    = 3'd4,
        CMD_LEP2    = 3'd5
    } t_cmd;

    // Datapath register-transfer operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SAT_FLAG,
        OP_DIV_Q,
        OP_PT_ZERO,
        OP_SQRT,
        OP_PT_WR,
        OP_DIV_F,
        OP_F_WR,
        OP_S_WR,
        OP_E_WR,
        OP_M_WR,
        OP_OUT
    } t_op;

    // Multiplier operand sources
    typedef enum logic [3:0] {
        MS_NONE,
        MS_DOT,
        MS_PMAG,
        MS_Q,
        MS_SCALE,
        MS_LMASS,
        MS_SSQ,
        MS_E,
        MS_P
    } t_msrc;

    // Accumulator operations
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_SUB
    } t_accop;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK,
        S_DOT,
        S_DOT_END,
        S_DIVQ,
        S_DIVQ_W,
        S_TR_CMP,
        S_TR_M1,
        S_TR_M2,
        S_TR_SQ,
        S_TR_SQW,
        S_FDIV,
        S_FDIV_W,
        S_SCMUL,
        S_SCWR,
        S_EN_LM,
        S_EN_SQ,
        S_EN_END,
        S_EN_SQRT,
        S_EN_W,
        S_MS_E,
        S_MS_P,
        S_MS_END,
        S_MS_SQRT,
        S_MS_W,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op        op;
        t_msrc      msrc;
        t_accop     acc;
        logic       side;
        logic [1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic fd_zero;
        logic q_ge_pmag;
        logic ptl_zero;
        logic div_busy;
        logic sqrt_busy;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== design/hcm_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hcm_div: restoring unsigned divider
// One quotient bit per cycle; the quotient holds until the next start.
// ---------------------------------------------------------------------------
module hcm_div #(
    parameter int N_W = 64,
    parameter int D_W = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_dividend,
    input  wire logic [D_W-1:0] i_divisor,
    output logic                o_busy,
    output logic [N_W-1:0]      o_quotient
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [N_W-1:0]   r_quo, n_quo;
    logic [D_W-1:0]   r_rem, n_rem;
    logic [D_W-1:0]   r_dsr, n_dsr;
    logic [D_W:0]     trial;

    // Shift in one dividend bit and subtract where it fits
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        trial  = {r_rem, r_quo[N_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(N_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dsr}) begin
                n_rem = D_W'(trial - {1'b0, r_dsr});
                n_quo = {r_quo[N_W-2:0], 1'b1};
            end else begin
                n_rem = trial[D_W-1:0];
                n_quo = {r_quo[N_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== design/hcm_sqrt.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hcm_sqrt: digit-by-digit integer square root
// Two radicand bits and one root bit per cycle; floor of the root.
// ---------------------------------------------------------------------------
module hcm_sqrt #(
    parameter int IN_W = 66
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [IN_W-1:0]   i_radicand,
    output logic                   o_busy,
    output logic [IN_W/2-1:0]      o_root
);
    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 4;
    localparam int CNT_W = $clog2(OUT_W + 1);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IN_W-1:0]  r_rad, n_rad;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [OUT_W-1:0] r_root, n_root;
    logic [REM_W-1:0] shifted, trial;

    // Bring down two bits, try root*4+1
    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_rad   = r_rad;
        n_rem   = r_rem;
        n_root  = r_root;
        shifted = {r_rem[REM_W-3:0], r_rad[IN_W-1:IN_W-2]};
        trial   = REM_W'({r_root, 2'b01});
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(OUT_W);
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            if (shifted >= trial) begin
                n_rem  = shifted - trial;
                n_root = {r_root[OUT_W-2:0], 1'b1};
            end else begin
                n_rem  = shifted;
                n_root = {r_root[OUT_W-2:0], 1'b0};
            end
            n_rad = {r_rad[IN_W-3:0], 2'b00};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule
`default_nettype wire

// ===== design/hcm_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hcm_dp: datapath of the HOP corrected mass block
// Event registers, one shared multiplier with accumulator, the divider and
// square-root units, and the result and output registers.
// ---------------------------------------------------------------------------
module hcm_dp #(
    parameter int FACTOR_FRAC_BITS = hcm_pkg::HCM_FRAC_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire hcm_pkg::t_dp_cmd                    i_cmd,
    output hcm_pkg::t_dp_stat                        o_stat,
    input  wire logic [hcm_pkg::CMD_W-1:0]           i_command,
    input  wire logic signed [hcm_pkg::COMP_W-1:0]   i_comp_x,
    input  wire logic signed [hcm_pkg::COMP_W-1:0]   i_comp_y,
    input  wire logic signed [hcm_pkg::COMP_W-1:0]   i_comp_z,
    input  wire logic [hcm_pkg::COMP_W-1:0]          i_extra_value,
    input  wire logic [hcm_pkg::COMP_W-1:0]          i_magnitude,
    input  wire logic                                i_cfg_we,
    input  wire logic [hcm_pkg::CFG_W-1:0]           i_cfg_data,
    output logic [hcm_pkg::FACTOR_W-1:0]             o_scale_factor,
    output logic signed [hcm_pkg::MASS_W-1:0]        o_corrected_mass,
    output logic signed [hcm_pkg::MASS_W-1:0]        o_dilepton_mass,
    output logic                                     o_status
);
    import hcm_pkg::*;

    function automatic logic [MUL_W-1:0] abs33(input logic signed [MUL_W-1:0] v);
        return v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
    endfunction

    // Event state
    logic signed [COMP_W-1:0] r_ev [3];
    logic signed [COMP_W-1:0] r_pv [3];
    logic signed [COMP_W-1:0] r_hp [3];
    logic signed [COMP_W-1:0] r_dp [3];
    logic signed [COMP_W-1:0] r_l1 [3];
    logic signed [COMP_W-1:0] r_l2 [3];
    logic [COMP_W-1:0]        r_fd, r_he, r_hm, r_dm;
    logic [CFG_W-1:0]         r_lm;

    // Working registers
    logic [COMP_W-1:0]        r_pt [2];
    logic [FACTOR_W-1:0]      r_f;
    logic                     r_stat;
    logic signed [COMP_W-1:0] r_s [2][3];
    logic [COMP_W-1:0]        r_e [2];
    logic signed [MASS_W-1:0] r_mass [2];
    logic [PROD_W-1:0]        r_prod;
    logic                     r_prod_neg;
    logic signed [ACC_W-1:0]  r_acc;

    // Output registers
    logic [FACTOR_W-1:0]      r_o_f;
    logic signed [MASS_W-1:0] r_o_cm, r_o_dm;
    logic                     r_o_st;

    logic signed [COMP_W-1:0] in_comp [3];
    logic signed [MUL_W-1:0]  d_sel, p_sel, v_sel, s_sel, dil_sel, tot_sel, pm_sel;
    logic [COMP_W-1:0]        pmag_sel;
    logic [MUL_W-1:0]         e_sum;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic                     mul_neg;
    logic [PROD_W-1:0]        mul_p;
    logic signed [ACC_W-1:0]  term;
    logic [ACC_W-1:0]         acc_abs;
    logic [PROD_W-1:0]        scaled;
    logic [COMP_W-1:0]        mclip;
    logic signed [COMP_W-1:0] s_val;

    logic                     div_start, div_busy;
    logic [DIV_N_W-1:0]       div_dividend, div_quo;
    logic [DIV_D_W-1:0]       div_divisor;
    logic                     sqrt_start, sqrt_busy;
    logic [SQ_OUT_W-1:0]      sqrt_root;

    assign in_comp[0] = i_comp_x;
    assign in_comp[1] = i_comp_y;
    assign in_comp[2] = i_comp_z;

    // Select operands for the current component and side
    always_comb begin
        d_sel    = {{2{r_ev[i_cmd.idx][COMP_W-1]}}, r_ev[i_cmd.idx]}
                 - {{2{r_pv[i_cmd.idx][COMP_W-1]}}, r_pv[i_cmd.idx]};
        p_sel    = i_cmd.side ? {{2{r_dp[i_cmd.idx][COMP_W-1]}}, r_dp[i_cmd.idx]}
                              : {{2{r_hp[i_cmd.idx][COMP_W-1]}}, r_hp[i_cmd.idx]};
        v_sel    = i_cmd.side ? {{2{r_l2[i_cmd.idx][COMP_W-1]}}, r_l2[i_cmd.idx]}
                              : {{2{r_l1[i_cmd.idx][COMP_W-1]}}, r_l1[i_cmd.idx]};
        s_sel    = {{2{r_s[i_cmd.side][i_cmd.idx][COMP_W-1]}}, r_s[i_cmd.side][i_cmd.idx]};
        dil_sel  = {{2{r_s[0][i_cmd.idx][COMP_W-1]}}, r_s[0][i_cmd.idx]}
                 + {{2{r_s[1][i_cmd.idx][COMP_W-1]}}, r_s[1][i_cmd.idx]};
        tot_sel  = dil_sel + {{2{r_hp[i_cmd.idx][COMP_W-1]}}, r_hp[i_cmd.idx]};
        pm_sel   = i_cmd.side ? dil_sel : tot_sel;
        pmag_sel = i_cmd.side ? r_dm : r_hm;
        e_sum    = MUL_W'(r_e[0]) + MUL_W'(r_e[1]) + (i_cmd.side ? '0 : MUL_W'(r_he));
    end

    // Route the multiplier inputs
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (i_cmd.msrc)
            MS_NONE: begin
            end
            MS_DOT: begin
                mul_a   = abs33(d_sel);
                mul_b   = abs33(p_sel);
                mul_neg = d_sel[MUL_W-1] ^ p_sel[MUL_W-1];
            end
            MS_PMAG: begin
                mul_a = MUL_W'(pmag_sel);
                mul_b = MUL_W'(pmag_sel);
            end
            MS_Q: begin
                mul_a = div_quo[MUL_W-1:0];
                mul_b = div_quo[MUL_W-1:0];
            end
            MS_SCALE: begin
                mul_a   = MUL_W'(r_f);
                mul_b   = abs33(v_sel);
                mul_neg = v_sel[MUL_W-1];
            end
            MS_LMASS: begin
                mul_a = MUL_W'(r_lm);
                mul_b = MUL_W'(r_lm);
            end
            MS_SSQ: begin
                mul_a = abs33(s_sel);
                mul_b = abs33(s_sel);
            end
            MS_E: begin
                mul_a = e_sum;
                mul_b = e_sum;
            end
            MS_P: begin
                mul_a = abs33(pm_sel);
                mul_b = abs33(pm_sel);
            end
            default: begin
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign term    = r_prod_neg ? -$signed({2'b00, r_prod}) : $signed({2'b00, r_prod});
    assign acc_abs = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    // Scaled lepton component, truncated then saturated
    always_comb begin
        scaled = r_prod >> FACTOR_FRAC_BITS;
        if (r_prod_neg) begin
            mclip = (scaled > PROD_W'(COMP_NEG_MAG)) ? COMP_NEG_MAG : scaled[COMP_W-1:0];
            s_val = $signed(COMP_W'(-mclip));
        end else begin
            mclip = (scaled > PROD_W'(COMP_POS_MAX)) ? COMP_POS_MAX : scaled[COMP_W-1:0];
            s_val = $signed(mclip);
        end
    end

    // Start the shared divider and square-root units
    always_comb begin
        div_start    = 1'b0;
        div_dividend = acc_abs[DIV_N_W-1:0];
        div_divisor  = DIV_D_W'(r_fd);
        if (i_cmd.op == OP_DIV_Q) begin
            div_start = 1'b1;
        end else if (i_cmd.op == OP_DIV_F) begin
            div_start    = 1'b1;
            div_dividend = DIV_N_W'(r_pt[0]) << FACTOR_FRAC_BITS;
            div_divisor  = DIV_D_W'(r_pt[1]);
        end
        sqrt_start = (i_cmd.op == OP_SQRT);
    end

    hcm_div #(
        .N_W (DIV_N_W),
        .D_W (DIV_D_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    hcm_sqrt #(
        .IN_W (SQ_IN_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (acc_abs[SQ_IN_W-1:0]),
        .o_busy     (sqrt_busy),
        .o_root     (sqrt_root)
    );

    // Load event state on each input transfer; write lepton mass on config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_ev[i] <= '0;
                r_pv[i] <= '0;
                r_hp[i] <= '0;
                r_dp[i] <= '0;
                r_l1[i] <= '0;
            end
            r_fd <= '0;
            r_he <= '0;
            r_hm <= '0;
            r_dm <= '0;
            r_lm <= LEPTON_MASS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_lm <= i_cfg_data;
            end
            if (i_cmd.op == OP_LOAD) begin
                unique case (t_cmd'(i_command))
                    CMD_END_VTX: begin
                        for (int i = 0; i < 3; i++) r_ev[i] <= in_comp[i];
                    end
                    CMD_PRI_VTX: begin
                        for (int i = 0; i < 3; i++) r_pv[i] <= in_comp[i];
                        r_fd <= i_extra_value;
                    end
                    CMD_HADRON: begin
                        for (int i = 0; i < 3; i++) r_hp[i] <= in_comp[i];
                        r_he <= i_extra_value;
                        r_hm <= i_magnitude;
                    end
                    CMD_DILEP: begin
                        for (int i = 0; i < 3; i++) r_dp[i] <= in_comp[i];
                        r_dm <= i_magnitude;
                    end
                    CMD_LEP1: begin
                        for (int i = 0; i < 3; i++) r_l1[i] <= in_comp[i];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working registers of one computation
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && t_cmd'(i_command) == CMD_LEP2) begin
            for (int i = 0; i < 3; i++) r_l2[i] <= in_comp[i];
        end
        if (i_cmd.msrc != MS_NONE) begin
            r_prod     <= mul_p;
            r_prod_neg <= mul_neg;
        end
        unique case (i_cmd.acc)
            ACC_HOLD:  r_acc <= r_acc;
            ACC_CLEAR: r_acc <= '0;
            ACC_ADD:   r_acc <= r_acc + term;
            ACC_SUB:   r_acc <= r_acc - term;
            default:   r_acc <= r_acc;
        endcase
        unique case (i_cmd.op)
            OP_SAT_FLAG: begin
                r_f    <= FACTOR_MAX;
                r_stat <= 1'b1;
            end
            OP_PT_ZERO: r_pt[i_cmd.side] <= '0;
            OP_PT_WR:   r_pt[i_cmd.side] <= sqrt_root[COMP_W-1:0];
            OP_F_WR: begin
                r_f    <= (div_quo > DIV_N_W'(FACTOR_MAX)) ? FACTOR_MAX
                                                           : div_quo[FACTOR_W-1:0];
                r_stat <= 1'b0;
            end
            OP_S_WR:    r_s[i_cmd.side][i_cmd.idx] <= s_val;
            OP_E_WR:    r_e[i_cmd.side] <= sqrt_root[COMP_W-1:0];
            OP_M_WR: begin
                r_mass[i_cmd.side] <= r_acc[ACC_W-1] ? -$signed({1'b0, sqrt_root})
                                                     : $signed({1'b0, sqrt_root});
            end
            OP_OUT: begin
                r_o_f  <= r_f;
                r_o_cm <= r_mass[0];
                r_o_dm <= r_mass[1];
                r_o_st <= r_stat;
            end
            default: begin
            end
        endcase
    end

    // Status back to the controller
    always_comb begin
        o_stat.fd_zero   = (r_fd == '0);
        o_stat.q_ge_pmag = (div_quo >= DIV_N_W'(pmag_sel));
        o_stat.ptl_zero  = (r_pt[1] == '0);
        o_stat.div_busy  = div_busy;
        o_stat.sqrt_busy = sqrt_busy;
    end

    assign o_scale_factor   = r_o_f;
    assign o_corrected_mass = r_o_cm;
    assign o_dilepton_mass  = r_o_dm;
    assign o_status         = r_o_st;

endmodule
`default_nettype wire

// ===== design/hcm_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hcm_ctrl: sequencer of the HOP corrected mass block
// Accepts input items, steps the datapath through the transverse momenta,
// factor, lepton scaling, energies and masses, and owns the output valid.
// ---------------------------------------------------------------------------
module hcm_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [hcm_pkg::CMD_W-1:0] i_command,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output hcm_pkg::t_dp_cmd               o_cmd,
    input  wire hcm_pkg::t_dp_stat         i_stat
);
    import hcm_pkg::*;

    t_state     r_state, n_state;
    logic       r_side, n_side;
    logic [1:0] r_idx, n_idx;
    logic       r_ov, n_ov;

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_side     = r_side;
        n_idx      = r_idx;
        o_cmd.op   = OP_NONE;
        o_cmd.msrc = MS_NONE;
        o_cmd.acc  = ACC_HOLD;
        o_cmd.side = r_side;
        o_cmd.idx  = r_idx;
        o_in_ready = 1'b0;
        n_ov       = r_ov;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (t_cmd'(i_command) == CMD_LEP2) begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                n_side = 1'b0;
                n_idx  = 2'd0;
                if (i_stat.fd_zero) begin
                    o_cmd.op = OP_SAT_FLAG;
                    n_state  = S_SCMUL;
                end else begin
                    n_state = S_DOT;
                end
            end
            // Dot product of flight line and momentum
            S_DOT: begin
                o_cmd.msrc = MS_DOT;
                o_cmd.acc  = (r_idx == 2'd0) ? ACC_CLEAR : ACC_ADD;
                n_idx      = r_idx + 2'd1;
                if (r_idx == 2'd2) begin
                    n_state = S_DOT_END;
                end
            end
            S_DOT_END: begin
                o_cmd.acc = ACC_ADD;
                n_state   = S_DIVQ;
            end
            S_DIVQ: begin
                o_cmd.op = OP_DIV_Q;
                n_state  = S_DIVQ_W;
            end
            S_DIVQ_W: begin
                if (!i_stat.div_busy) begin
                    n_state = S_TR_CMP;
                end
            end
            // Clamp, else P^2 - q^2
            S_TR_CMP: begin
                if (i_stat.q_ge_pmag) begin
                    o_cmd.op = OP_PT_ZERO;
                    n_idx    = 2'd0;
                    if (r_side == 1'b0) begin
                        n_side  = 1'b1;
                        n_state = S_DOT;
                    end else begin
                        n_state = S_FDIV;
                    end
                end else begin
                    o_cmd.msrc = MS_PMAG;
                    o_cmd.acc  = ACC_CLEAR;
                    n_state    = S_TR_M1;
                end
            end
            S_TR_M1: begin
                o_cmd.msrc = MS_Q;
                o_cmd.acc  = ACC_ADD;
                n_state    = S_TR_M2;
            end
            S_TR_M2: begin
                o_cmd.acc = ACC_SUB;
                n_state   = S_TR_SQ;
            end
            S_TR_SQ: begin
                o_cmd.op = OP_SQRT;
                n_state  = S_TR_SQW;
            end
            S_TR_SQW: begin
                if (!i_stat.sqrt_busy) begin
                    o_cmd.op = OP_PT_WR;
                    n_idx    = 2'd0;
                    if (r_side == 1'b0) begin
                        n_side  = 1'b1;
                        n_state = S_DOT;
                    end else begin
                        n_state = S_FDIV;
                    end
                end
            end
            // Scale factor
            S_FDIV: begin
                n_side = 1'b0;
                n_idx  = 2'd0;
                if (i_stat.ptl_zero) begin
                    o_cmd.op = OP_SAT_FLAG;
                    n_state  = S_SCMUL;
                end else begin
                    o_cmd.op = OP_DIV_F;
                    n_state  = S_FDIV_W;
                end
            end
            S_FDIV_W: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_F_WR;
                    n_state  = S_SCMUL;
                end
            end
            // Scale lepton components
            S_SCMUL: begin
                o_cmd.msrc = MS_SCALE;
                n_state    = S_SCWR;
            end
            S_SCWR: begin
                o_cmd.op = OP_S_WR;
                n_state  = S_SCMUL;
                if (r_idx == 2'd2) begin
                    n_idx = 2'd0;
                    if (r_side == 1'b0) begin
                        n_side = 1'b1;
                    end else begin
                        n_side  = 1'b0;
                        n_state = S_EN_LM;
                    end
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            // Lepton energies
            S_EN_LM: begin
                o_cmd.msrc = MS_LMASS;
                o_cmd.acc  = ACC_CLEAR;
                n_idx      = 2'd0;
                n_state    = S_EN_SQ;
            end
            S_EN_SQ: begin
                o_cmd.msrc = MS_SSQ;
                o_cmd.acc  = ACC_ADD;
                n_idx      = r_idx + 2'd1;
                if (r_idx == 2'd2) begin
                    n_state = S_EN_END;
                end
            end
            S_EN_END: begin
                o_cmd.acc = ACC_ADD;
                n_state   = S_EN_SQRT;
            end
            S_EN_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_state  = S_EN_W;
            end
            S_EN_W: begin
                if (!i_stat.sqrt_busy) begin
                    o_cmd.op = OP_E_WR;
                    n_idx    = 2'd0;
                    if (r_side == 1'b0) begin
                        n_side  = 1'b1;
                        n_state = S_EN_LM;
                    end else begin
                        n_side  = 1'b0;
                        n_state = S_MS_E;
                    end
                end
            end
            // Invariant masses: total first, then dilepton
            S_MS_E: begin
                o_cmd.msrc = MS_E;
                o_cmd.acc  = ACC_CLEAR;
                n_idx      = 2'd0;
                n_state    = S_MS_P;
            end
            S_MS_P: begin
                o_cmd.msrc = MS_P;
                o_cmd.acc  = (r_idx == 2'd0) ? ACC_ADD : ACC_SUB;
                n_idx      = r_idx + 2'd1;
                if (r_idx == 2'd2) begin
                    n_state = S_MS_END;
                end
            end
            S_MS_END: begin
                o_cmd.acc = ACC_SUB;
                n_state   = S_MS_SQRT;
            end
            S_MS_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_state  = S_MS_W;
            end
            S_MS_W: begin
                if (!i_stat.sqrt_busy) begin
                    o_cmd.op = OP_M_WR;
                    n_idx    = 2'd0;
                    if (r_side == 1'b0) begin
                        n_side  = 1'b1;
                        n_state = S_MS_E;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            // Hold until the output register is free
            S_OUT: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.op = OP_OUT;
                    n_ov     = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_side  <= 1'b0;
            r_idx   <= 2'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
            r_idx   <= n_idx;
            r_ov    <= n_ov;
        end
    end

    assign o_out_valid = r_ov;

endmodule
`default_nettype wire

// ===== design/hop_corrected_mass.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hop_corrected_mass: HOP momentum-balance corrected invariant mass
// Loads an event through typed items and returns one mass result per event.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one item per transfer,
//   selected by i_command: end vertex, primary vertex with flight distance,
//   hadron, dilepton, lepton one, and lepton two.
//   Lepton two starts the computation; the block takes no further input until
//   its result is placed in the output register, the soonest when the flight
//   distance is zero and sooner when a momentum is clamped. The time is set by
//   the shared 64-step divider (up to three runs) and the 33-step square-root
//   unit (up to six runs).
//   Output channel (o_out_valid / i_out_ready) holds the result in a register;
//   load items are still taken while it waits. A stalled receiver holds the
//   next result in its last step until the register frees up.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the lepton mass in keV
//   and is always ready; write it only while the block is idle.
//   Reset clears all event state but lepton two, sets the lepton mass to
//   511 keV and drops any pending result.
// ---------------------------------------------------------------------------
module hop_corrected_mass #(
    parameter int FACTOR_FRAC_BITS = hcm_pkg::HCM_FRAC_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [hcm_pkg::CMD_W-1:0]         i_command,
    input  wire logic signed [hcm_pkg::COMP_W-1:0] i_comp_x,
    input  wire logic signed [hcm_pkg::COMP_W-1:0] i_comp_y,
    input  wire logic signed [hcm_pkg::COMP_W-1:0] i_comp_z,
    input  wire logic [hcm_pkg::COMP_W-1:0]        i_extra_value,
    input  wire logic [hcm_pkg::COMP_W-1:0]        i_magnitude,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [hcm_pkg::FACTOR_W-1:0]           o_scale_factor,
    output logic signed [hcm_pkg::MASS_W-1:0]      o_corrected_mass,
    output logic signed [hcm_pkg::MASS_W-1:0]      o_dilepton_mass,
    output logic                                   o_status,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [hcm_pkg::CFG_W-1:0]         i_cfg_data
);
    import hcm_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Config writes are always accepted
    assign o_cfg_ready = 1'b1;

    hcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    hcm_dp #(
        .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_command        (i_command),
        .i_comp_x         (i_comp_x),
        .i_comp_y         (i_comp_y),
        .i_comp_z         (i_comp_z),
        .i_extra_value    (i_extra_value),
        .i_magnitude      (i_magnitude),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .o_scale_factor   (o_scale_factor),
        .o_corrected_mass (o_corrected_mass),
        .o_dilepton_mass  (o_dilepton_mass),
        .o_status         (o_status)
    );

endmodule
`default_nettype wire

// ===== bench/hop_corrected_mass_test.sv =====
// ---------------------------------------------------------------------------
// hop_corrected_mass_test: self-checking bench for the HOP corrected mass block
// Loads events through the input channel, predicts every mass result with a
// bit-accurate scoreboard, and checks each output transfer in order. The
// lepton mass register is rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module hop_corrected_mass_test;
    import hcm_pkg::*;

    localparam int FRAC          = HCM_FRAC_BITS;
    localparam int ITEM_TARGET   = 1050;
    localparam int QUIET_FROM    = 900;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
    localparam longint C_MAX = 64'sh3FFF_FFFF;
    localparam longint C_MIN = -64'sh4000_0000;

    typedef struct {
        logic [FACTOR_W-1:0] factor;
        logic [MASS_W-1:0]   corr_mass;
        logic [MASS_W-1:0]   dilep_mass;
        logic                status;
    } mass_result_t;

    // Event predictor plus queue of pending mass results
    class mass_scoreboard;
        longint          end_vtx[3], pri_vtx[3], had_p[3], dil_p[3], lep1_p[3];
        longint unsigned flight, had_e, had_mag, dil_mag, lep_mass;
        mass_result_t    pending[$];
        int              errors;
        int              results_seen;
        int              saturated_seen;
        int              negative_seen;

        function new();
            for (int i = 0; i < 3; i++) begin
                end_vtx[i] = 0; pri_vtx[i] = 0; had_p[i] = 0; dil_p[i] = 0; lep1_p[i] = 0;
            end
            flight = 0; had_e = 0; had_mag = 0; dil_mag = 0;
            lep_mass = LEPTON_MASS_RESET;
            errors = 0; results_seen = 0; saturated_seen = 0; negative_seen = 0;
        endfunction

        function void set_mass(logic [CFG_W-1:0] m);
            lep_mass = m;
        endfunction

        function longint unsigned absval(longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        function longint unsigned isqrt(logic [127:0] x);
            longint unsigned r;
            longint unsigned c;
            r = 0;
            for (int b = 63; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (x >= {64'd0, c} * {64'd0, c}) r = c;
            end
            return r;
        endfunction

        function longint unsigned pt_of(longint d[3], longint p[3], longint unsigned pm);
            longint dot;
            longint unsigned q;
            dot = d[0] * p[0] + d[1] * p[1] + d[2] * p[2];
            q = absval(dot) / flight;
            if (q >= pm) return 0;
            return isqrt({64'd0, pm * pm - q * q});
        endfunction

        function longint scaled(longint unsigned f, longint v);
            longint unsigned m;
            m = (f * absval(v)) >> FRAC;
            if (v < 0) begin
                if (m > 64'h4000_0000) m = 64'h4000_0000;
                return -longint'(m);
            end
            if (m > C_MAX) m = C_MAX;
            return longint'(m);
        endfunction

        function longint unsigned energy_of(longint s[3]);
            logic [127:0] w;
            w = {64'd0, lep_mass} * {64'd0, lep_mass};
            for (int i = 0; i < 3; i++) w += {64'd0, absval(s[i])} * {64'd0, absval(s[i])};
            return isqrt(w);
        endfunction

        function logic [MASS_W-1:0] mass_of(longint unsigned e, longint p[3]);
            logic [127:0] e2, p2;
            longint m;
            e2 = {64'd0, e} * {64'd0, e};
            p2 = 0;
            for (int i = 0; i < 3; i++) p2 += {64'd0, absval(p[i])} * {64'd0, absval(p[i])};
            if (e2 >= p2) m = longint'(isqrt(e2 - p2));
            else m = -longint'(isqrt(p2 - e2));
            return m[MASS_W-1:0];
        endfunction

        // Record an accepted input transfer; lepton two queues one result
        function void note(logic [CMD_W-1:0] cmd, longint v[3],
                           logic [COMP_W-1:0] extra, logic [COMP_W-1:0] mag);
            longint d[3], s1[3], s2[3], dil[3], tot[3];
            longint unsigned f, pth, ptl, e1, e2;
            mass_result_t r;
            case (cmd)
                CMD_END_VTX: end_vtx = v;
                CMD_PRI_VTX: begin pri_vtx = v; flight = extra; end
                CMD_HADRON:  begin had_p = v; had_e = extra; had_mag = mag; end
                CMD_DILEP:   begin dil_p = v; dil_mag = mag; end
                CMD_LEP1:    lep1_p = v;
                CMD_LEP2: begin
                    f = FACTOR_MAX;
                    r.status = 1'b1;
                    for (int i = 0; i < 3; i++) d[i] = end_vtx[i] - pri_vtx[i];
                    if (flight != 0) begin
                        pth = pt_of(d, had_p, had_mag);
                        ptl = pt_of(d, dil_p, dil_mag);
                        if (ptl != 0) begin
                            f = (pth << FRAC) / ptl;
                            if (f > FACTOR_MAX) f = FACTOR_MAX;
                            r.status = 1'b0;
                        end
                    end
                    for (int i = 0; i < 3; i++) begin
                        s1[i] = scaled(f, lep1_p[i]);
                        s2[i] = scaled(f, v[i]);
                        dil[i] = s1[i] + s2[i];
                        tot[i] = dil[i] + had_p[i];
                    end
                    e1 = energy_of(s1);
                    e2 = energy_of(s2);
                    r.factor     = f[FACTOR_W-1:0];
                    r.corr_mass  = mass_of(e1 + e2 + had_e, tot);
                    r.dilep_mass = mass_of(e1 + e2, dil);
                    pending.push_back(r);
                end
                default: ;
            endcase
        endfunction

        // Compare one output transfer with the oldest prediction
        function void check(logic [FACTOR_W-1:0] f, logic [MASS_W-1:0] cm,
                            logic [MASS_W-1:0] dm, logic st);
            mass_result_t r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result factor=%h", $time, f);
                errors++;
                return;
            end
            r = pending.pop_front();
            results_seen++;
            if (r.status) saturated_seen++;
            if (r.corr_mass[MASS_W-1] || r.dilep_mass[MASS_W-1]) negative_seen++;
            if (f !== r.factor) begin
                $display("%0t: scale_factor expected %h actual %h", $time, r.factor, f);
                errors++;
            end
            if (cm !== r.corr_mass) begin
                $display("%0t: corrected_mass expected %h actual %h", $time, r.corr_mass, cm);
                errors++;
            end
            if (dm !== r.dilep_mass) begin
                $display("%0t: dilepton_mass expected %h actual %h", $time, r.dilep_mass, dm);
                errors++;
            end
            if (st !== r.status) begin
                $display("%0t: status expected %b actual %b", $time, r.status, st);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [CMD_W-1:0]         i_command;
    logic signed [COMP_W-1:0] i_comp_x, i_comp_y, i_comp_z;
    logic [COMP_W-1:0]        i_extra_value, i_magnitude;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [FACTOR_W-1:0]      o_scale_factor;
    logic signed [MASS_W-1:0] o_corrected_mass, o_dilepton_mass;
    logic                     o_status;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_W-1:0]         i_cfg_data;

    mass_scoreboard sb;
    bit             quiet;
    int             items_sent;
    int             idle_count;

    hop_corrected_mass DUT (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_command,
        .i_comp_x, .i_comp_y, .i_comp_z, .i_extra_value, .i_magnitude,
        .o_out_valid, .i_out_ready, .o_scale_factor, .o_corrected_mass,
        .o_dilepton_mass, .o_status, .i_cfg_valid, .o_cfg_ready, .i_cfg_data
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // Observe transfers on all three channels
    always @(posedge i_clk) begin
        longint v[3];
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check(o_scale_factor, o_corrected_mass, o_dilepton_mass, o_status);
            if (i_in_valid && o_in_ready) begin
                v[0] = i_comp_x; v[1] = i_comp_y; v[2] = i_comp_z;
                sb.note(i_command, v, i_extra_value, i_magnitude);
            end
            if (i_cfg_valid && o_cfg_ready) sb.set_mass(i_cfg_data);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_MAX) begin
                $display("%0t: watchdog expired", $time);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver: stall in random bursts until the quiet part of the run
    initial begin
        int n;
        i_out_ready = 1'b1;
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 7);
                @(negedge i_clk) i_out_ready = 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                n = $urandom_range(1, 10);
                @(negedge i_clk) i_out_ready = 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    task automatic send(logic [CMD_W-1:0] cmd, longint x, longint y, longint z,
                        longint unsigned extra, longint unsigned mag);
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_command     = cmd;
        i_comp_x      = x[COMP_W-1:0];
        i_comp_y      = y[COMP_W-1:0];
        i_comp_z      = z[COMP_W-1:0];
        i_extra_value = extra[COMP_W-1:0];
        i_magnitude   = mag[COMP_W-1:0];
        do @(posedge i_clk); while (!o_in_ready);
        if (cmd != CMD_SPARE_A && cmd != CMD_SPARE_B) items_sent++;
    endtask

    // Drop valid for a random burst of cycles
    task automatic sender_gap();
        int n;
        n = $urandom_range(1, 7);
        @(negedge i_clk) i_in_valid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk) i_in_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mass(logic [CFG_W-1:0] m);
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = m;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk) i_cfg_valid = 1'b0;
    endtask

    function automatic longint rand_comp(int unsigned span);
        longint r;
        if ($urandom_range(0, 7) == 0) begin
            r = $urandom;
            return longint'(r[30:0]) - (r[30] ? 64'sh8000_0000 : 0);
        end
        return longint'($urandom_range(0, 2 * span)) - longint'(span);
    endfunction

    // One event: load items in random order, then lepton two
    task automatic random_event();
        int order[5];
        int j, t;
        longint px, py, pz;
        for (int i = 0; i < 5; i++) order[i] = i;
        for (int i = 4; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i]; order[i] = order[j]; order[j] = t;
        end
        px = rand_comp(100000); py = rand_comp(100000); pz = rand_comp(100000);
        for (int i = 0; i < 5; i++) begin
            if (!quiet && $urandom_range(0, 3) == 0) sender_gap();
            case (order[i])
                0: send(CMD_END_VTX, px + rand_comp(20000), py + rand_comp(20000),
                        pz + rand_comp(20000), $urandom, $urandom);
                1: send(CMD_PRI_VTX, px, py, pz,
                        $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 40000), $urandom);
                2: send(CMD_HADRON, rand_comp(2000000), rand_comp(2000000),
                        rand_comp(2000000), $urandom_range(0, 32'h7FFF_FFFF),
                        $urandom_range(0, 8000000));
                3: send(CMD_DILEP, rand_comp(2000000), rand_comp(2000000),
                        rand_comp(2000000), $urandom,
                        $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 8000000));
                default: send(CMD_LEP1, rand_comp(1000000), rand_comp(1000000),
                              rand_comp(1000000), $urandom, $urandom);
            endcase
        end
        if (!quiet && $urandom_range(0, 3) == 0) sender_gap();
        send(CMD_LEP2, rand_comp(1000000), rand_comp(1000000), rand_comp(1000000),
             $urandom, $urandom);
    endtask

    initial begin
        bit paused;
        sb = new();
        quiet = 0; items_sent = 0; paused = 0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_command = CMD_END_VTX;
        i_comp_x = '0; i_comp_y = '0; i_comp_z = '0;
        i_extra_value = '0; i_magnitude = '0;
        i_cfg_valid = 1'b0; i_cfg_data = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero flight distance straight out of reset
        send(CMD_LEP2, 1000, -2000, 3000, 0, 0);
        send(CMD_END_VTX, 3000, 4000, 0, 0, 0);
        send(CMD_PRI_VTX, 0, 0, 0, 5000, 0);
        send(CMD_HADRON, 1000, 2000, 3000, 5000000, 4000000);
        // Zero dilepton magnitude
        send(CMD_DILEP, 500, -600, 700, 0, 0);
        send(CMD_LEP1, 20000, -30000, 40000, 0, 0);
        send(CMD_LEP2, -10000, 15000, 25000, 0, 0);
        // Normal event
        send(CMD_DILEP, 500, -600, 700, 0, 300000);
        send(CMD_LEP2, -10000, 15000, 25000, 0, 0);
        // Zero hadron magnitude
        send(CMD_HADRON, 1000, 2000, 3000, 5000000, 0);
        send(CMD_LEP2, -10000, 15000, 25000, 0, 0);
        // Factor overflow, then saturated lepton components
        send(CMD_HADRON, 1000, 2000, 3000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(CMD_DILEP, 0, 0, 1, 32'h7FFF_FFFF, 1);
        send(CMD_LEP1, C_MAX, C_MIN, 12345, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(CMD_LEP2, C_MIN, C_MAX, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // Negative mass square: heavy hadron momentum, no energy
        send(CMD_HADRON, C_MAX, C_MIN, C_MAX, 0, 1000000);
        send(CMD_DILEP, 500, -600, 700, 0, 300000);
        send(CMD_LEP1, 1, -1, 0, 0, 0);
        send(CMD_LEP2, 0, 1, -1, 0, 0);
        // Unknown commands are ignored
        send(CMD_SPARE_A, -1, -1, -1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(CMD_SPARE_B, C_MAX, C_MIN, -1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // Extreme vertices with unit flight distance
        send(CMD_END_VTX, C_MIN, C_MAX, -1, 0, 0);
        send(CMD_PRI_VTX, C_MAX, C_MIN, 0, 1, 0);
        send(CMD_LEP2, 7, 8, 9, 0, 0);

        write_mass('0);
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= QUIET_FROM) quiet = 1;
            if (items_sent >= 350 && items_sent < 360) write_mass(20'd1000000);
            if (items_sent >= 700 && items_sent < 710)
                write_mass(CFG_W'($urandom_range(0, 1000000)));
            if (!paused && items_sent >= 500) begin
                drain();
                paused = 1;
            end
            if ($urandom_range(0, 9) == 0) begin
                // Noise: one item with a random command, mostly zero components and random other fields
                send(CMD_W'($urandom_range(0, 7)), rand_comp(0), rand_comp(0), rand_comp(0),
                     $urandom, $urandom);
            end else begin
                random_event();
            end
        end

        drain();
        $display("Checked %0d mass results (%0d with saturated factor, %0d with negative mass)",
                 sb.results_seen, sb.saturated_seen, sb.negative_seen);
        $display("over %0d load and compute items across four lepton mass settings",
                 items_sent);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
